FILE: sv/drvmix_pkg.sv
// Shared types and constants for the drive mode mixer.
`timescale 1ns / 1ps

package drvmix_pkg;

	localparam int CHANNEL_WIDTH_DEF = 12;
	localparam int PULSE_W           = 12;
	localparam int STEP_W            = 10;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 12;

	localparam int NEUTRAL = 1500;

	localparam logic [PULSE_W-1:0] STICK_LOW_RST  = 12'd1300;
	localparam logic [PULSE_W-1:0] STICK_HIGH_RST = 12'd1700;
	localparam logic [STEP_W-1:0]  SERVO_STEP_RST = 10'd30;
	localparam logic [PULSE_W-1:0] SERVO_MIN_RST  = 12'd250;
	localparam logic [PULSE_W-1:0] SERVO_MAX_RST  = 12'd1250;
	localparam logic [PULSE_W-1:0] SERVO_MID_RST  = 12'd750;
	localparam logic [PULSE_W-1:0] MOTOR_MIN_RST  = 12'd800;
	localparam logic [PULSE_W-1:0] MOTOR_MAX_RST  = 12'd2100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STICK_LOW  = 3'd0,
		CFG_STICK_HIGH = 3'd1,
		CFG_SERVO_STEP = 3'd2,
		CFG_SERVO_MIN  = 3'd3,
		CFG_SERVO_MAX  = 3'd4,
		CFG_SERVO_MID  = 3'd5,
		CFG_MOTOR_MIN  = 3'd6,
		CFG_MOTOR_MAX  = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_FWD   = 2'd0,
		MODE_REV   = 2'd1,
		MODE_SPLIT = 2'd2
	} mode_t;

endpackage

FILE: sv/drive_mode_mixer_top.sv
// Drive mode mixer top level: mode select, servo nudge and four-motor mix.
//
// Input channel: in_valid / in_stall with op and four RC channels. A word is
// taken at a rising edge with in_valid high and in_stall low. op = 1 is a
// control tick (mode switch and servo stick update), op = 0 a motor tick.
// Output channel: out_valid / out_stall with four motor pulses, the servo
// pulse, the drive mode and the mode_entered flag; one result word per input.
// Config port: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data;
// write registers only while no word is in flight.
// Path: a taken word passes through the input register, then the result register.
// Throughput: one word per cycle while out_stall is low; on a control tick the
// mode and servo state update in the same cycle a word moves from the input
// register to the result register, so the next word sees it at once.
// Stall: the result register holds while out_stall is high; one more word
// may wait in the input register, after which in_stall goes high.
// Reset: config returns to defaults, mode 0, servo 250, last switch 1500,
// both registers empty.
`timescale 1ns / 1ps

module drive_mode_mixer_top #(
	parameter int CHANNEL_WIDTH = drvmix_pkg::CHANNEL_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [CHANNEL_WIDTH-1:0]            steer_in,
	input  logic [CHANNEL_WIDTH-1:0]            throttle_in,
	input  logic [CHANNEL_WIDTH-1:0]            servo_stick_in,
	input  logic [CHANNEL_WIDTH-1:0]            mode_switch_in,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [drvmix_pkg::PULSE_W-1:0]      motor_one,
	output logic [drvmix_pkg::PULSE_W-1:0]      motor_two,
	output logic [drvmix_pkg::PULSE_W-1:0]      motor_three,
	output logic [drvmix_pkg::PULSE_W-1:0]      motor_four,
	output logic [drvmix_pkg::PULSE_W-1:0]      servo_pulse,
	output logic [1:0]                          drive_mode,
	output logic                                mode_entered,
	// config write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [drvmix_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [drvmix_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import drvmix_pkg::*;

	// signed width covering steer + throttle + 4500 at a channel width of 10 bits or more
	localparam int MW    = CHANNEL_WIDTH + 4;
	localparam int CMP_W = (CHANNEL_WIDTH > PULSE_W) ? CHANNEL_WIDTH : PULSE_W;

	// config registers
	logic [PULSE_W-1:0] stick_low_q, stick_high_q, servo_min_q, servo_max_q;
	logic [PULSE_W-1:0] servo_mid_q, motor_min_q, motor_max_q;
	logic [STEP_W-1:0]  servo_step_q;

	// state
	mode_t                    mode_q;
	logic [PULSE_W-1:0]       servo_q;
	logic [CHANNEL_WIDTH-1:0] last_sw_q;

	// input register
	logic                     valid_s1;
	logic                     op_s1;
	logic [CHANNEL_WIDTH-1:0] steer_s1, thr_s1, stick_s1, sw_s1;

	// result register
	logic               out_valid_q;
	logic [PULSE_W-1:0] m1_q, m2_q, m3_q, m4_q, servo_out_q;
	mode_t              mode_out_q;
	logic               entered_q;

	logic adv, take_in;

	logic [CMP_W-1:0]         sw_c, stick_c, lo_c, hi_c;
	logic                     entered;
	mode_t                    mode_sel, mode_cur;
	logic signed [MW-1:0]     sp, step_x, smin_x, smax_x;
	logic [PULSE_W-1:0]       servo_nx;
	logic signed [MW-1:0]     thr_x, steer_x, neu_x, neu3_x;
	logic signed [MW-1:0]     mix_a, mix_b, mix_ra, mix_rb, mmin_x, mmax_x;
	logic [PULSE_W-1:0]       m1, m2, m3, m4;

	function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [MW-1:0] v,
			input logic signed [MW-1:0] lo, input logic signed [MW-1:0] hi);
		logic signed [MW-1:0] t;
		t = v;
		if (t < lo) t = lo;
		if (t > hi) t = hi;
		return t[PULSE_W-1:0];
	endfunction

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take_in  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_low_q  <= STICK_LOW_RST;
			stick_high_q <= STICK_HIGH_RST;
			servo_step_q <= SERVO_STEP_RST;
			servo_min_q  <= SERVO_MIN_RST;
			servo_max_q  <= SERVO_MAX_RST;
			servo_mid_q  <= SERVO_MID_RST;
			motor_min_q  <= MOTOR_MIN_RST;
			motor_max_q  <= MOTOR_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_STICK_LOW:  stick_low_q  <= cfg_data[PULSE_W-1:0];
				CFG_STICK_HIGH: stick_high_q <= cfg_data[PULSE_W-1:0];
				CFG_SERVO_STEP: servo_step_q <= cfg_data[STEP_W-1:0];
				CFG_SERVO_MIN:  servo_min_q  <= cfg_data[PULSE_W-1:0];
				CFG_SERVO_MAX:  servo_max_q  <= cfg_data[PULSE_W-1:0];
				CFG_SERVO_MID:  servo_mid_q  <= cfg_data[PULSE_W-1:0];
				CFG_MOTOR_MIN:  motor_min_q  <= cfg_data[PULSE_W-1:0];
				CFG_MOTOR_MAX:  motor_max_q  <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// mode select and servo nudge
	always_comb begin
		sw_c    = CMP_W'(sw_s1);
		stick_c = CMP_W'(stick_s1);
		lo_c    = CMP_W'(stick_low_q);
		hi_c    = CMP_W'(stick_high_q);
		step_x  = $signed(MW'(servo_step_q));
		smin_x  = $signed(MW'(servo_min_q));
		smax_x  = $signed(MW'(servo_max_q));

		entered = op_s1 && (sw_s1 != last_sw_q);

		if (sw_c < lo_c) begin
			mode_sel = MODE_FWD;
		end else if (sw_c > hi_c) begin
			mode_sel = MODE_SPLIT;
		end else begin
			mode_sel = MODE_REV;
		end

		if (entered) begin
			mode_cur = mode_sel;
			case (mode_sel)
				MODE_FWD:   sp = smin_x;
				MODE_SPLIT: sp = $signed(MW'(servo_mid_q));
				default:    sp = smax_x;
			endcase
		end else begin
			mode_cur = mode_q;
			sp       = $signed(MW'(servo_q));
		end

		if (stick_c > hi_c) sp = sp + step_x;
		if (stick_c < lo_c) sp = sp - step_x;
		servo_nx = clamp_pulse(sp, smin_x, smax_x);
	end

	// skid-steer mix, signed
	always_comb begin
		thr_x   = $signed(MW'(thr_s1));
		steer_x = $signed(MW'(steer_s1));
		neu_x   = $signed(MW'(NEUTRAL));
		neu3_x  = $signed(MW'(3 * NEUTRAL));
		mmin_x  = $signed(MW'(motor_min_q));
		mmax_x  = $signed(MW'(motor_max_q));

		mix_a  = thr_x - neu_x + steer_x;
		mix_b  = thr_x + neu_x - steer_x;
		mix_ra = neu_x - thr_x + steer_x;
		mix_rb = neu3_x - thr_x - steer_x;

		case (mode_cur)
			MODE_FWD: begin
				m1 = clamp_pulse(mix_a, mmin_x, mmax_x);
				m2 = clamp_pulse(mix_b, mmin_x, mmax_x);
				m3 = m2;
				m4 = m1;
			end
			MODE_REV: begin
				m1 = clamp_pulse(mix_ra, mmin_x, mmax_x);
				m2 = clamp_pulse(mix_rb, mmin_x, mmax_x);
				m3 = m2;
				m4 = m1;
			end
			default: begin
				m1 = clamp_pulse(mix_a, mmin_x, mmax_x);
				m2 = clamp_pulse(mix_b, mmin_x, mmax_x);
				m3 = clamp_pulse(mix_rb, mmin_x, mmax_x);
				m4 = clamp_pulse(mix_ra, mmin_x, mmax_x);
			end
		endcase
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1    <= op;
			steer_s1 <= steer_in;
			thr_s1   <= throttle_in;
			stick_s1 <= servo_stick_in;
			sw_s1    <= mode_switch_in;
		end
	end

	// state moves with a control word (op = 1) leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_FWD;
			servo_q   <= SERVO_MIN_RST;
			last_sw_q <= CHANNEL_WIDTH'(NEUTRAL);
		end else if (adv && op_s1) begin
			mode_q    <= mode_cur;
			servo_q   <= servo_nx;
			last_sw_q <= sw_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_q        <= m1;
			m2_q        <= m2;
			m3_q        <= m3;
			m4_q        <= m4;
			servo_out_q <= op_s1 ? servo_nx : servo_q;
			mode_out_q  <= mode_cur;
			entered_q   <= entered;
		end
	end

	assign out_valid    = out_valid_q;
	assign motor_one    = m1_q;
	assign motor_two    = m2_q;
	assign motor_three  = m3_q;
	assign motor_four   = m4_q;
	assign servo_pulse  = servo_out_q;
	assign drive_mode   = mode_out_q;
	assign mode_entered = entered_q;

endmodule

FILE: sv/drvmix_chk.sv
// Port-level checker for the drive mode mixer, bound to the top level.
`timescale 1ns / 1ps

module drvmix_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [drvmix_pkg::PULSE_W-1:0] motor_one,
	input logic [drvmix_pkg::PULSE_W-1:0] motor_two,
	input logic [drvmix_pkg::PULSE_W-1:0] motor_three,
	input logic [drvmix_pkg::PULSE_W-1:0] motor_four,
	input logic [drvmix_pkg::PULSE_W-1:0] servo_pulse,
	input logic [1:0]                     drive_mode,
	input logic                           mode_entered
);
	import drvmix_pkg::*;

	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(motor_one) && $stable(motor_two) &&
			$stable(motor_three) && $stable(motor_four) && $stable(servo_pulse) &&
			$stable(drive_mode) && $stable(mode_entered))
		else $error("result word changed under stall");

	// input backs up only behind a blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// a word held in the input register keeps the input stalled while the output is blocked
	a_stall_chain: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (in_stall == out_stall))
		else $error("input stall does not follow output stall");

endmodule

bind drive_mode_mixer_top drvmix_chk u_drvmix_chk (.*);

FILE: verif/tb_drive_mode_mixer_top.sv
// Self-checking testbench for drive_mode_mixer_top: directed table, random words, config sweeps.
`timescale 1ns / 1ps

module tb_drive_mode_mixer_top;
	import drvmix_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int PHASES      = 8;
	localparam int WORDS_PER_PH = 210;
	localparam int DRILL_N     = 22;
	localparam int RUN_LIMIT   = 500000;

	typedef struct packed {
		logic        op;
		logic [11:0] steer;
		logic [11:0] throttle;
		logic [11:0] stick;
		logic [11:0] sw;
	} rc_word_t;

	typedef struct packed {
		logic [11:0] m1;
		logic [11:0] m2;
		logic [11:0] m3;
		logic [11:0] m4;
		logic [11:0] servo;
		logic [1:0]  mode;
		logic        entered;
	} mix_result_t;

	typedef struct packed {
		rc_word_t    w;
		logic        known;
		mix_result_t want;
	} drill_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic op;
	logic [11:0] steer_in;
	logic [11:0] throttle_in;
	logic [11:0] servo_stick_in;
	logic [11:0] mode_switch_in;
	logic out_valid;
	logic out_stall;
	logic [PULSE_W-1:0] motor_one;
	logic [PULSE_W-1:0] motor_two;
	logic [PULSE_W-1:0] motor_three;
	logic [PULSE_W-1:0] motor_four;
	logic [PULSE_W-1:0] servo_pulse;
	logic [1:0] drive_mode;
	logic mode_entered;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow copy of the block's registers and state
	logic [11:0] lo_thr = STICK_LOW_RST;
	logic [11:0] hi_thr = STICK_HIGH_RST;
	logic [9:0]  s_step = SERVO_STEP_RST;
	logic [11:0] s_min  = SERVO_MIN_RST;
	logic [11:0] s_max  = SERVO_MAX_RST;
	logic [11:0] s_mid  = SERVO_MID_RST;
	logic [11:0] m_min  = MOTOR_MIN_RST;
	logic [11:0] m_max  = MOTOR_MAX_RST;
	mode_t       mode_now = MODE_FWD;
	logic [11:0] servo_now = SERVO_MIN_RST;
	logic [11:0] last_sw = 12'(NEUTRAL);

	mix_result_t expected_mix[$];
	drill_row_t  drill_tab [DRILL_N];
	logic [11:0] sw_held = 12'(NEUTRAL);
	bit          idle_on;
	int          mismatch_cnt;
	int          words_sent;
	int          reselect_cnt;
	int          cycle_cnt;

	drive_mode_mixer_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.steer_in       (steer_in),
		.throttle_in    (throttle_in),
		.servo_stick_in (servo_stick_in),
		.mode_switch_in (mode_switch_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.motor_one      (motor_one),
		.motor_two      (motor_two),
		.motor_three    (motor_three),
		.motor_four     (motor_four),
		.servo_pulse    (servo_pulse),
		.drive_mode     (drive_mode),
		.mode_entered   (mode_entered),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// raise below lo first, then cut above hi: inverted limits give hi
	function automatic int clip(int v, int lo, int hi);
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	function automatic mix_result_t mix_predict(rc_word_t w);
		mix_result_t r;
		int sp;
		int st;
		int th;
		int dlt;
		int fwd;
		int rev;
		int pulse [4];
		int v;
		r.entered = 1'b0;
		if (w.op) begin
			sp = servo_now;
			if (w.sw != last_sw) begin
				r.entered = 1'b1;
				if (w.sw < lo_thr) begin
					mode_now = MODE_FWD;
					sp = s_min;
				end else if (w.sw > hi_thr) begin
					mode_now = MODE_SPLIT;
					sp = s_mid;
				end else begin
					mode_now = MODE_REV;
					sp = s_max;
				end
			end
			if (w.stick > hi_thr)
				sp = sp + int'(s_step);
			if (w.stick < lo_thr)
				sp = sp - int'(s_step);
			sp = clip(sp, s_min, s_max);
			servo_now = sp[11:0];
			last_sw = w.sw;
		end
		st = w.steer;
		th = w.throttle;
		dlt = NEUTRAL - st;
		fwd = th;
		rev = 2 * NEUTRAL - th;
		case (mode_now)
			MODE_FWD: begin
				pulse[0] = fwd - dlt;
				pulse[1] = fwd + dlt;
				pulse[2] = fwd + dlt;
				pulse[3] = fwd - dlt;
			end
			MODE_REV: begin
				pulse[0] = rev - dlt;
				pulse[1] = rev + dlt;
				pulse[2] = rev + dlt;
				pulse[3] = rev - dlt;
			end
			default: begin
				pulse[0] = fwd - dlt;
				pulse[1] = fwd + dlt;
				pulse[2] = rev + dlt;
				pulse[3] = rev - dlt;
			end
		endcase
		for (int i = 0; i < 4; i++)
			pulse[i] = clip(pulse[i], m_min, m_max);
		v = pulse[0];
		r.m1 = v[11:0];
		v = pulse[1];
		r.m2 = v[11:0];
		v = pulse[2];
		r.m3 = v[11:0];
		v = pulse[3];
		r.m4 = v[11:0];
		r.servo = servo_now;
		r.mode = mode_now;
		return r;
	endfunction

	function automatic void shadow_reg(cfg_idx_t idx, logic [11:0] val);
		case (idx)
			CFG_STICK_LOW:  lo_thr = val;
			CFG_STICK_HIGH: hi_thr = val;
			CFG_SERVO_STEP: s_step = val[9:0];
			CFG_SERVO_MIN:  s_min = val;
			CFG_SERVO_MAX:  s_max = val;
			CFG_SERVO_MID:  s_mid = val;
			CFG_MOTOR_MIN:  m_min = val;
			default:        m_max = val;
		endcase
	endfunction

	// channel values cluster around the thresholds and neutral, with some full range
	function automatic logic [11:0] rand_chan();
		int v;
		case ($urandom_range(0, 7))
			0, 1: v = $urandom_range(0, 4095);
			2: v = int'(lo_thr) + int'($urandom_range(0, 4)) - 2;
			3: v = int'(hi_thr) + int'($urandom_range(0, 4)) - 2;
			default: v = $urandom_range(900, 2100);
		endcase
		return v[11:0];
	endfunction

	function automatic rc_word_t rand_word();
		rc_word_t w;
		w.op = ($urandom_range(0, 1) == 1);
		w.steer = rand_chan();
		w.throttle = rand_chan();
		w.stick = rand_chan();
		// mostly hold the switch so that mode changes stay occasional
		w.sw = ($urandom_range(0, 4) < 3) ? sw_held : rand_chan();
		sw_held = w.sw;
		return w;
	endfunction

	function automatic logic [7:0][11:0] pick_regs(int ph);
		logic [7:0][11:0] r;
		case (ph)
			1: r = '0;
			2: r = '1;
			3: begin
				r[CFG_STICK_LOW]  = 12'd1800;
				r[CFG_STICK_HIGH] = 12'd1200;
				r[CFG_SERVO_STEP] = 12'd500;
				r[CFG_SERVO_MIN]  = 12'd3000;
				r[CFG_SERVO_MAX]  = 12'd100;
				r[CFG_SERVO_MID]  = 12'd2000;
				r[CFG_MOTOR_MIN]  = 12'd3000;
				r[CFG_MOTOR_MAX]  = 12'd500;
			end
			PHASES - 1: begin
				r[CFG_STICK_LOW]  = STICK_LOW_RST;
				r[CFG_STICK_HIGH] = STICK_HIGH_RST;
				r[CFG_SERVO_STEP] = 12'(SERVO_STEP_RST);
				r[CFG_SERVO_MIN]  = SERVO_MIN_RST;
				r[CFG_SERVO_MAX]  = SERVO_MAX_RST;
				r[CFG_SERVO_MID]  = SERVO_MID_RST;
				r[CFG_MOTOR_MIN]  = MOTOR_MIN_RST;
				r[CFG_MOTOR_MAX]  = MOTOR_MAX_RST;
			end
			default: begin
				r[CFG_STICK_LOW]  = 12'($urandom_range(800, 1600));
				r[CFG_STICK_HIGH] = 12'($urandom_range(1400, 2400));
				r[CFG_SERVO_STEP] = 12'($urandom_range(0, 4095));
				r[CFG_SERVO_MIN]  = 12'($urandom_range(0, 1500));
				r[CFG_SERVO_MAX]  = 12'($urandom_range(1000, 4095));
				r[CFG_SERVO_MID]  = 12'($urandom_range(0, 4095));
				r[CFG_MOTOR_MIN]  = 12'($urandom_range(0, 2000));
				r[CFG_MOTOR_MAX]  = 12'($urandom_range(1000, 4095));
			end
		endcase
		return r;
	endfunction

	task automatic load_regs(input logic [7:0][11:0] vals);
		cfg_valid <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			shadow_reg(cfg_idx_t'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(input rc_word_t w, input logic known, input mix_result_t want);
		mix_result_t pred;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= w.op;
		steer_in <= w.steer;
		throttle_in <= w.throttle;
		servo_stick_in <= w.stick;
		mode_switch_in <= w.sw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// predictor still runs on fixed rows to keep the shadow state in step
		pred = mix_predict(w);
		expected_mix.push_back(known ? want : pred);
		words_sent++;
	endtask

	// drain results, then allow for the pipeline before touching registers
	task automatic settle();
		while (expected_mix.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		mix_result_t seen;
		mix_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {motor_one, motor_two, motor_three, motor_four, servo_pulse,
				drive_mode, mode_entered};
			if (mode_entered === 1'b1)
				reselect_cnt++;
			if (expected_mix.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("[%0t] result word with none pending: %p", $realtime, seen);
			end else begin
				want = expected_mix.pop_front();
				if (seen.m1 !== want.m1 || seen.m2 !== want.m2 || seen.m3 !== want.m3 ||
					seen.m4 !== want.m4 || seen.servo !== want.servo ||
					seen.mode !== want.mode || seen.entered !== want.entered) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("[%0t] mismatch: expected %p actual %p", $realtime, want, seen);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > RUN_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 24);
			repeat (n)
				@(posedge clk);
			if (idle_on && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17))
					@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		op <= 1'b0;
		steer_in <= 12'(NEUTRAL);
		throttle_in <= 12'(NEUTRAL);
		servo_stick_in <= 12'(NEUTRAL);
		mode_switch_in <= 12'(NEUTRAL);
		cfg_valid <= 1'b0;
		cfg_index <= CFG_STICK_LOW;
		cfg_data <= '0;
		cycle_cnt = 0;
		mismatch_cnt = 0;
		words_sent = 0;
		reselect_cnt = 0;
		idle_on = 1'b1;
		// op, steer, throttle, stick, switch | fixed? | m1..m4, servo, mode, entered
		drill_tab = '{
			'{'{1'b0, 12'd1500, 12'd1500, 12'd1500, 12'd1500}, 1'b1,
				'{12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd250, MODE_FWD, 1'b0}},
			'{'{1'b0, 12'd0, 12'd0, 12'd1500, 12'd1500}, 1'b1,
				'{12'd800, 12'd1500, 12'd1500, 12'd800, 12'd250, MODE_FWD, 1'b0}},
			'{'{1'b0, 12'd4095, 12'd4095, 12'd1500, 12'd1500}, 1'b1,
				'{12'd2100, 12'd1500, 12'd1500, 12'd2100, 12'd250, MODE_FWD, 1'b0}},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1500, 12'd1500}, 1'b1,
				'{12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd250, MODE_FWD, 1'b0}},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1500, 12'd4095}, 1'b1,
				'{12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd750, MODE_SPLIT, 1'b1}},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd4095, 12'd4095}, 1'b0, '0},
			'{'{1'b0, 12'd0, 12'd4095, 12'd0, 12'd0}, 1'b0, '0},
			'{'{1'b0, 12'd4095, 12'd0, 12'd4095, 12'd4095}, 1'b0, '0},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd0, 12'd0}, 1'b1,
				'{12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd250, MODE_FWD, 1'b1}},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd4095, 12'd1500}, 1'b1,
				'{12'd1500, 12'd1500, 12'd1500, 12'd1500, 12'd1250, MODE_REV, 1'b1}},
			'{'{1'b1, 12'd0, 12'd0, 12'd1500, 12'd1500}, 1'b0, '0},
			'{'{1'b1, 12'd4095, 12'd4095, 12'd0, 12'd1500}, 1'b0, '0},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1500, 12'd1300}, 1'b0, '0},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1500, 12'd1299}, 1'b0, '0},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1500, 12'd1700}, 1'b0, '0},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1500, 12'd1701}, 1'b0, '0},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1701, 12'd1701}, 1'b0, '0},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1700, 12'd1701}, 1'b0, '0},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1300, 12'd1701}, 1'b0, '0},
			'{'{1'b1, 12'd1500, 12'd1500, 12'd1299, 12'd1701}, 1'b0, '0},
			'{'{1'b0, 12'd2730, 12'd1365, 12'd2730, 12'd1365}, 1'b0, '0},
			'{'{1'b1, 12'd1365, 12'd2730, 12'd2730, 12'd1365}, 1'b0, '0}
		};
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DRILL_N; i++)
			send_word(drill_tab[i].w, drill_tab[i].known, drill_tab[i].want);
		sw_held = 12'd1365;
		in_valid <= 1'b0;
		settle();

		// phase 0 keeps reset settings; then zeros, all ones, inverted limits,
		// random settings (phase 5 without idling), and finally the defaults again with no idling
		for (int ph = 0; ph < PHASES; ph++) begin
			idle_on = !(ph == 5 || ph == PHASES - 1);
			if (ph != 0)
				load_regs(pick_regs(ph));
			// let a stall burst still running end before an idle-free phase
			while (!idle_on && out_stall)
				@(posedge clk);
			for (int k = 0; k < WORDS_PER_PH; k++)
				send_word(rand_word(), 1'b0, '0);
			in_valid <= 1'b0;
			settle();
		end

		$display("covered %0d words over %0d register settings incl. zero, full and inverted",
			words_sent, PHASES);
		$display("mode reselections seen: %0d, mismatching words: %0d",
			reselect_cnt, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: drive_mode_mixer_top.f
sv/drvmix_pkg.sv
sv/drive_mode_mixer_top.sv
sv/drvmix_chk.sv
verif/tb_drive_mode_mixer_top.sv
